// File: rtl/blrle_pkg.sv
package blrle_pkg;

    localparam int CodeW      = 8;
    localparam int PosW       = 16;
    localparam int CmdBytes   = 4;
    localparam int CountW     = 3;
    localparam int IdxW       = 2;
    localparam int CfgIndexW  = 2;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;
    localparam int QueueCntW  = 3;

    localparam logic [CodeW-1:0] RUN_MAX = 8'd255;

    localparam logic [CfgIndexW-1:0] REG_IMAGE_ROWS = 2'd0;
    localparam logic [CfgIndexW-1:0] REG_IMAGE_COLS = 2'd1;

    // One pixel's worth of code bytes, oldest in entry 0.
    typedef struct packed {
        logic [CmdBytes-1:0][CodeW-1:0] bytes;
        logic [CountW-1:0]              count;
        logic                           done;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: rtl/blrle_front.sv
module blrle_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [blrle_pkg::CfgIndexW-1:0]       cfg_index,
    input  logic [blrle_pkg::CodeW-1:0]           cfg_data,
    input  logic                                  pixel,
    input  logic                                  pixel_valid,
    output logic                                  pixel_stall,
    input  blrle_pkg::queue_status_t              q_status,
    output logic                                  push,
    output blrle_pkg::cmd_t                       push_cmd
);
    import blrle_pkg::*;

    logic [CodeW-1:0]  rows_reg, rows_next;
    logic [CodeW-1:0]  cols_reg, cols_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic [CodeW-1:0]  len_reg, len_next;
    logic              color_reg, color_next;

    logic [CodeW-1:0]  rows_eff;
    logic [CodeW-1:0]  cols_eff;
    logic [PosW-1:0]   total;
    logic              last;
    logic              accept;
    logic [CountW-1:0] k;
    cmd_t              cmd;

    assign pixel_stall = q_status.full;
    assign accept      = pixel_valid && !pixel_stall;

    // Treat a zero dimension as one.
    assign rows_eff = (rows_reg == '0) ? CodeW'(1) : rows_reg;
    assign cols_eff = (cols_reg == '0) ? CodeW'(1) : cols_reg;
    assign total    = PosW'(rows_eff) * PosW'(cols_eff);
    assign last     = ({1'b0, pos_reg} + (PosW+1)'(1)) >= {1'b0, total};

    always_comb
    begin
        cmd        = '0;
        k          = '0;
        len_next   = len_reg;
        color_next = color_reg;
        pos_next   = pos_reg;
        if (pos_reg == '0)
        begin
            cmd.bytes[0] = rows_eff;
            cmd.bytes[1] = cols_eff;
            k            = CountW'(2);
        end
        if (pixel == color_reg)
        begin
            if (len_reg >= RUN_MAX)
            begin
                // Split: full run, then an empty run of the other color.
                cmd.bytes[k[IdxW-1:0]]          = RUN_MAX;
                cmd.bytes[k[IdxW-1:0] + IdxW'(1)] = '0;
                k        = k + CountW'(2);
                len_next = CodeW'(1);
            end
            else
            begin
                len_next = len_reg + CodeW'(1);
            end
        end
        else
        begin
            cmd.bytes[k[IdxW-1:0]] = len_reg;
            k          = k + CountW'(1);
            color_next = ~color_reg;
            len_next   = CodeW'(1);
        end
        if (last)
        begin
            cmd.bytes[k[IdxW-1:0]] = len_next;
            k          = k + CountW'(1);
            cmd.done   = 1'b1;
            pos_next   = '0;
            len_next   = '0;
            color_next = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + PosW'(1);
        end
        cmd.count = k;
    end

    assign push     = accept && (k != '0);
    assign push_cmd = cmd;

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_ROWS: rows_next = cfg_data;
                REG_IMAGE_COLS: cols_next = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= CodeW'(1);
            cols_reg  <= CodeW'(1);
            pos_reg   <= '0;
            len_reg   <= '0;
            color_reg <= 1'b1;
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
            if (accept)
            begin
                pos_reg   <= pos_next;
                len_reg   <= len_next;
                color_reg <= color_next;
            end
        end
    end

endmodule

// File: rtl/blrle_queue.sv
module blrle_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  blrle_pkg::cmd_t           push_cmd,
    input  logic                      pop,
    output blrle_pkg::cmd_t           head,
    output blrle_pkg::queue_status_t  status
);
    import blrle_pkg::*;

    cmd_t                 entry_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0] cnt_reg, cnt_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == QueueCntW'(QueueDepth));
    assign status.empty = (cnt_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QueuePtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QueuePtrW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QueueCntW'(push) - QueueCntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/blrle_back.sv
module blrle_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  blrle_pkg::cmd_t                  head,
    input  blrle_pkg::queue_status_t         q_status,
    output logic                             pop,
    output logic [blrle_pkg::CodeW-1:0]      code_byte,
    output logic                             last_of_item,
    output logic                             image_done,
    output logic                             code_valid,
    input  logic                             code_stall
);
    import blrle_pkg::*;

    logic [IdxW-1:0]  idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [CodeW-1:0] byte_reg;
    logic             last_reg;
    logic             done_reg;

    logic             out_free;
    logic             emit;
    logic             is_last;

    assign out_free = !valid_reg || !code_stall;
    assign emit     = !q_status.empty && out_free;
    assign is_last  = ({1'b0, idx_reg} + CountW'(1)) == head.count;
    assign pop      = emit && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && code_stall;
        if (emit)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? '0 : idx_reg + IdxW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= head.bytes[idx_reg];
            last_reg <= is_last;
            done_reg <= is_last && head.done;
        end
    end

    assign code_byte    = byte_reg;
    assign last_of_item = last_reg;
    assign image_done   = done_reg;
    assign code_valid   = valid_reg;

endmodule

// File: rtl/bilevel_run_length_encoder_unit.sv
// Path: a pixel's code bytes are written into the command queue, then registered onto code_byte.
// Throughput: one pixel per cycle while the four-entry command queue has room; the output
// side drains one code byte per cycle while code_stall is low.
// Reset (rst_n low, asynchronous): both dimensions go to 1, the next pixel opens a new image
// with a run of pixel value 1, the queue empties and no code byte is shown.
module bilevel_run_length_encoder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [blrle_pkg::CfgIndexW-1:0]     cfg_index,
    input  logic [blrle_pkg::CodeW-1:0]         cfg_data,
    input  logic                                pixel,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    output logic [blrle_pkg::CodeW-1:0]         code_byte,
    output logic                                last_of_item,
    output logic                                image_done,
    output logic                                code_valid,
    input  logic                                code_stall
);
    import blrle_pkg::*;

    // Front end: hold dimensions and run state, turn each pixel into a command
    // of zero to four code bytes, push only commands that carry bytes.
    logic          push;
    cmd_t          push_cmd;
    // Queue between front and back: absorb bursts so each side can stall alone.
    logic          pop;
    cmd_t          head;
    queue_status_t q_status;

    blrle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .q_status    (q_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    blrle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // Back end: walk the head command one byte per cycle, while the output is not stalled, into the output
    // register, advance to the next command after its last byte.
    blrle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .code_byte    (code_byte),
        .last_of_item (last_of_item),
        .image_done   (image_done),
        .code_valid   (code_valid),
        .code_stall   (code_stall)
    );

    // The end of an image always closes the item that caused it.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && image_done |-> last_of_item)
        else $error("image_done without last_of_item");

    // Never push into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("command pushed into full queue");

    // A command landing in an idle pipe passes the queue entry, then the output register, to code_valid.
    a_fast_path: assert property (@(posedge clk) disable iff (!rst_n)
        push && q_status.empty && !code_valid |-> ##2 code_valid)
        else $error("code byte did not appear after push into idle pipe");

    // Pop only when the output register takes a byte.
    a_pop_moves_byte: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty && (!code_valid || !code_stall))
        else $error("command popped without emitting a byte");

endmodule
